/* sv/assert_macros.svh */
// Assertion helpers used by the cipher top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* sv/pfdc_pkg.sv */
package pfdc_pkg;

  // Square geometry and special letters.
  localparam int unsigned SIDE    = 5;
  localparam int unsigned CELLS   = 25;
  localparam int unsigned LETTERS = 26;
  localparam logic [4:0] LET_I     = 5'd8;
  localparam logic [4:0] LET_J     = 5'd9;
  localparam logic [4:0] LET_Z     = 5'd25;
  localparam logic [4:0] CELLS_5B  = 5'd25;
  localparam logic [2:0] LAST_IDX  = 3'd4;

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_KEY    = 3'd1,
    OP_FINISH = 3'd2,
    OP_ENC    = 3'd3,
    OP_DEC    = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_LOOK,
    ST_RES
  } state_e;

  typedef enum logic [1:0] {
    RULE_ROW,
    RULE_COL,
    RULE_RECT
  } rule_e;

  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
  } pos_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic [4:0] first_letter;
    logic [4:0] second_letter;
    logic       pad_second;
  } in_word_t;

  typedef struct packed {
    logic [4:0] out_first;
    logic [4:0] out_second;
    logic       status;
  } out_word_t;

  // Letter codes above z read as z.
  function automatic logic [4:0] sat_letter(logic [4:0] v);
    return (v > LET_Z) ? LET_Z : v;
  endfunction

  // Digraph letter: saturate, then j folds onto i.
  function automatic logic [4:0] map_letter(logic [4:0] v);
    logic [4:0] s;
    s = sat_letter(v);
    return (s == LET_J) ? LET_I : s;
  endfunction

  // One step around a row or column of the square, forward or back.
  function automatic logic [2:0] step5(logic [2:0] v, logic dec);
    logic [2:0] r;
    if (dec) begin
      r = (v == 3'd0) ? LAST_IDX : v - 3'd1;
    end else begin
      r = (v == LAST_IDX) ? 3'd0 : v + 3'd1;
    end
    return r;
  endfunction

  // Linear square index, row times five plus column.
  function automatic logic [4:0] cell_index(pos_t p);
    return ({2'b00, p.row} << 2) + {2'b00, p.row} + {2'b00, p.col};
  endfunction

endpackage

/* sv/pfdc_lane.sv */
module pfdc_lane (
  input  pfdc_pkg::pos_t  own_i,
  input  pfdc_pkg::pos_t  other_i,
  input  pfdc_pkg::rule_e rule_i,
  input  logic            dec_i,
  output logic [4:0]      cell_o
);

  // Move this letter's position by the rule that both lanes share.
  always_comb begin
    pfdc_pkg::pos_t tgt;
    tgt = own_i;
    unique case (rule_i)
      pfdc_pkg::RULE_ROW:  tgt.col = pfdc_pkg::step5(own_i.col, dec_i);
      pfdc_pkg::RULE_COL:  tgt.row = pfdc_pkg::step5(own_i.row, dec_i);
      pfdc_pkg::RULE_RECT: tgt.col = other_i.col;
      default:             tgt = own_i;
    endcase
    cell_o = pfdc_pkg::cell_index(tgt);
  end

endmodule

/* sv/pfdc_merge.sv */
module pfdc_merge (
  input  pfdc_pkg::pos_t      pos_a_i,
  input  pfdc_pkg::pos_t      pos_b_i,
  output pfdc_pkg::rule_e     rule_o,
  input  logic [4:0]          letter_a_i,
  input  logic [4:0]          letter_b_i,
  input  logic                err_i,
  output pfdc_pkg::out_word_t res_o
);

  // Compare the two lanes' positions; a doubled letter falls under the row rule.
  always_comb begin
    priority if (pos_a_i.row == pos_b_i.row) begin
      rule_o = pfdc_pkg::RULE_ROW;
    end else if (pos_a_i.col == pos_b_i.col) begin
      rule_o = pfdc_pkg::RULE_COL;
    end else begin
      rule_o = pfdc_pkg::RULE_RECT;
    end
  end

  // Join the lanes' letters into one result word; an unfinished key gives zeros.
  always_comb begin
    res_o.out_first  = err_i ? 5'd0 : letter_a_i;
    res_o.out_second = err_i ? 5'd0 : letter_b_i;
    res_o.status     = err_i;
  end

endmodule

/* sv/playfair_digraph_cipher.sv */
// Channel | Direction | Word         | Handshake
// in      | input     | in_data_i    | in_valid_i, in_stall_o
// out     | output    | out_data_o   | out_valid_o, out_stall_i
//
// Clear and key-letter words are done on acceptance; a finish word on an unready key
// starts the fill walk over all 26 letters, which places the missing ones, one per cycle.
// An encrypt or decrypt word passes position lookup, square lookup
// in the two letter lanes, then the output register; before the key is finished
// it skips the square lookup. The position and square memories each have two read ports.
// Reset clears the placed flags, fill count and ready flag; no clearing pass.
// A stalled output holds the result in the result state until it drains.
`include "assert_macros.svh"

module playfair_digraph_cipher (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pfdc_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pfdc_pkg::out_word_t out_data_o
);

  pfdc_pkg::state_e state_q, state_d;

  logic [25:0] placed_q;
  logic [4:0]  fill_q;
  logic [2:0]  fill_row_q, fill_col_q;
  logic        ready_q;
  logic [4:0]  walk_q;

  logic        dec_q, err_q;
  pfdc_pkg::pos_t pos_a_q, pos_b_q;
  logic [4:0]  sq_a_q, sq_b_q;

  logic        out_valid_q;
  pfdc_pkg::out_word_t out_q;

  pfdc_pkg::pos_t pos_mem [pfdc_pkg::LETTERS];
  logic [4:0]     sq_mem  [pfdc_pkg::CELLS];

  logic       accept;
  logic       busy, fill_active, look_active, res_load, out_free;
  logic       place_req, place_en;
  logic [4:0] place_let;
  logic [4:0] let_a, let_b;
  logic       op_clear, op_key, op_finish, op_cipher, op_dec;
  logic       walk_done;

  pfdc_pkg::rule_e     rule;
  logic [4:0]          cell_a, cell_b;
  pfdc_pkg::out_word_t res;

  // Opcode decode of the incoming word.
  always_comb begin
    op_clear  = 1'b0;
    op_key    = 1'b0;
    op_finish = 1'b0;
    op_cipher = 1'b0;
    op_dec    = 1'b0;
    unique case (in_data_i.opcode)
      pfdc_pkg::OP_CLEAR:  op_clear  = 1'b1;
      pfdc_pkg::OP_KEY:    op_key    = 1'b1;
      pfdc_pkg::OP_FINISH: op_finish = 1'b1;
      pfdc_pkg::OP_ENC:    op_cipher = 1'b1;
      pfdc_pkg::OP_DEC: begin
        op_cipher = 1'b1;
        op_dec    = 1'b1;
      end
      default: ;
    endcase
  end

  assign accept    = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign walk_done = (walk_q == pfdc_pkg::LET_Z);

  // Digraph letters after padding and folding of j.
  assign let_a = pfdc_pkg::map_letter(in_data_i.first_letter);
  assign let_b = in_data_i.pad_second ? pfdc_pkg::LET_Z
                                      : pfdc_pkg::map_letter(in_data_i.second_letter);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pfdc_pkg::ST_IDLE: begin
        if (accept && op_finish && !ready_q) begin
          state_d = pfdc_pkg::ST_FILL;
        end else if (accept && op_cipher) begin
          state_d = ready_q ? pfdc_pkg::ST_LOOK : pfdc_pkg::ST_RES;
        end
      end
      pfdc_pkg::ST_FILL: if (walk_done) state_d = pfdc_pkg::ST_IDLE;
      pfdc_pkg::ST_LOOK: state_d = pfdc_pkg::ST_RES;
      pfdc_pkg::ST_RES:  if (out_free) state_d = pfdc_pkg::ST_IDLE;
      default:           state_d = pfdc_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    busy        = 1'b1;
    fill_active = 1'b0;
    look_active = 1'b0;
    res_load    = 1'b0;
    unique case (state_q)
      pfdc_pkg::ST_IDLE: busy        = 1'b0;
      pfdc_pkg::ST_FILL: fill_active = 1'b1;
      pfdc_pkg::ST_LOOK: look_active = 1'b1;
      pfdc_pkg::ST_RES:  res_load    = out_free;
      default:           busy        = 1'b1;
    endcase
  end

  assign in_stall_o = busy;

  // Placement of one letter, from a key word or from the finish walk.
  assign place_req = fill_active || (accept && op_key && !ready_q);
  assign place_let = fill_active ? walk_q : pfdc_pkg::sat_letter(in_data_i.first_letter);
  assign place_en  = place_req && (place_let != pfdc_pkg::LET_J) &&
                     !placed_q[place_let] && (fill_q < pfdc_pkg::CELLS_5B);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= pfdc_pkg::ST_IDLE;
      placed_q   <= '0;
      fill_q     <= '0;
      fill_row_q <= '0;
      fill_col_q <= '0;
      ready_q    <= 1'b0;
      walk_q     <= '0;
    end else begin
      state_q <= state_d;
      if (accept && op_clear) begin
        placed_q   <= '0;
        fill_q     <= '0;
        fill_row_q <= '0;
        fill_col_q <= '0;
        ready_q    <= 1'b0;
      end else if (place_en) begin
        placed_q[place_let] <= 1'b1;
        fill_q              <= fill_q + 5'd1;
        if (fill_col_q == pfdc_pkg::LAST_IDX) begin
          fill_col_q <= '0;
          fill_row_q <= fill_row_q + 3'd1;
        end else begin
          fill_col_q <= fill_col_q + 3'd1;
        end
      end
      if (accept && op_finish) begin
        walk_q <= '0;
      end else if (fill_active) begin
        walk_q <= walk_q + 5'd1;
      end
      if (fill_active && walk_done) begin
        ready_q <= 1'b1;
      end
    end
  end

  // Letter position memory: written on placement, read for both digraph letters.
  always_ff @(posedge clk_i) begin
    if (place_en) begin
      pos_mem[place_let] <= '{row: fill_row_q, col: fill_col_q};
    end
    if (accept && op_cipher) begin
      pos_a_q <= pos_mem[let_a];
      pos_b_q <= pos_mem[let_b];
      dec_q   <= op_dec;
      err_q   <= !ready_q;
    end
  end

  // Merge stage decides the rule from the two positions.
  pfdc_merge u_merge (
    .pos_a_i    (pos_a_q),
    .pos_b_i    (pos_b_q),
    .rule_o     (rule),
    .letter_a_i (sq_a_q),
    .letter_b_i (sq_b_q),
    .err_i      (err_q),
    .res_o      (res)
  );

  // One lane for each letter of the digraph.
  pfdc_lane u_lane_a (
    .own_i   (pos_a_q),
    .other_i (pos_b_q),
    .rule_i  (rule),
    .dec_i   (dec_q),
    .cell_o  (cell_a)
  );

  pfdc_lane u_lane_b (
    .own_i   (pos_b_q),
    .other_i (pos_a_q),
    .rule_i  (rule),
    .dec_i   (dec_q),
    .cell_o  (cell_b)
  );

  // Square memory: written on placement, read at both lanes' cells.
  always_ff @(posedge clk_i) begin
    if (place_en) begin
      sq_mem[fill_q] <= place_let;
    end
    if (look_active) begin
      sq_a_q <= sq_mem[cell_a];
      sq_b_q <= sq_mem[cell_b];
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_SAME(a_fill_bound, clk_i, rst_ni, 1'b1, fill_q <= pfdc_pkg::CELLS_5B)
  `ASSERT_SAME(a_ready_full, clk_i, rst_ni, ready_q, fill_q == pfdc_pkg::CELLS_5B)
  `ASSERT_NEXT(a_res_load, clk_i, rst_ni, state_q == pfdc_pkg::ST_RES && out_free, out_valid_q)

endmodule
